@@ sv/stec_pkg.sv @@
// ----------------------------------------------------------------------------
// stec_pkg
// Shared types, constants and helpers for the shift tensor coefficient block.
// ----------------------------------------------------------------------------
package stec_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int VALUE_BITS   = 24;
    localparam int OUT_BITS     = VALUE_BITS + 2;
    localparam int CORDIC_STEPS = 28;
    localparam int STEP_BITS    = 5;
    localparam int PHASE_BITS   = 32;
    localparam int TRIG_BITS    = 18;
    localparam int IN_BITS      = 3 * VALUE_BITS + 3 * ANGLE_BITS;
    localparam int IN_BYTES     = (IN_BITS + 7) / 8;
    localparam int OUT_BYTES    = (3 * OUT_BITS + 7) / 8;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [17:0] TRIG_ONE    = 18'sd65536;

    // one cordic lane: rotating vector, residual angle and quadrant
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         quad;
    } cordic_t;

    typedef struct packed {
        logic signed [17:0] c;
        logic signed [17:0] s;
    } trig_t;

    // arctangent table in units of 2^-32 turn
    function automatic logic signed [31:0] atan_turn(input logic [STEP_BITS-1:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2F9;  5'd15: v = 32'h0000517C;
                5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A2F;  5'd19: v = 32'h00000517;
                5'd20: v = 32'h0000028B;  5'd21: v = 32'h00000145;
                5'd22: v = 32'h000000A2;  5'd23: v = 32'h00000051;
                5'd24: v = 32'h00000028;  5'd25: v = 32'h00000014;
                5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
                default: v = 32'h00000000;
            endcase
            atan_turn = signed'(v);
        end
    endfunction

    // q16 product, rounded half up
    function automatic logic signed [17:0] mul_q16(input logic signed [17:0] a,
                                                   input logic signed [17:0] b);
        logic signed [35:0] p;
        begin
            p = a * b;
            mul_q16 = 18'((p + 36'sd32768) >>> 16);
        end
    endfunction

    // saturate to the output width
    function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [31:0] v);
        logic signed [31:0] lim;
        begin
            lim = 32'sd1 <<< (OUT_BITS - 1);
            if (v >= lim)
                sat_out = OUT_BITS'(lim - 32'sd1);
            else if (v < -lim)
                sat_out = OUT_BITS'(-lim);
            else
                sat_out = OUT_BITS'(v);
        end
    endfunction

endpackage

@@ sv/stec_cell.sv @@
// ----------------------------------------------------------------------------
// stec_cell
// One cordic rotation step, registered, handing its vector to the next cell.
// ----------------------------------------------------------------------------
module stec_cell (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [stec_pkg::STEP_BITS-1:0]  step,
    input  stec_pkg::cordic_t               cin,
    output stec_pkg::cordic_t               cout
);
    import stec_pkg::*;

    cordic_t cell_reg, cell_next;
    logic signed [31:0] xs, ys, at;

    // rotate toward zero residual angle
    always_comb begin
        xs = cin.x >>> step;
        ys = cin.y >>> step;
        at = atan_turn(step);
        cell_next.quad = cin.quad;
        if (!cin.z[31]) begin
            cell_next.x = cin.x - ys;
            cell_next.y = cin.y + xs;
            cell_next.z = cin.z - at;
        end else begin
            cell_next.x = cin.x + ys;
            cell_next.y = cin.y - xs;
            cell_next.z = cin.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cout = cell_reg;

endmodule

@@ sv/stec_sincos.sv @@
// ----------------------------------------------------------------------------
// stec_sincos
// Pipelined q16 cosine and sine of a 32-bit phase: a row of cordic cells
// followed by a rounding and quadrant fold stage.
// ----------------------------------------------------------------------------
module stec_sincos (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [stec_pkg::PHASE_BITS-1:0]    phase,
    output stec_pkg::trig_t                    trig
);
    import stec_pkg::*;

    cordic_t chain [CORDIC_STEPS+1];
    trig_t   trig_reg, trig_next;
    logic signed [31:0] xr, yr;
    logic signed [17:0] xc, yc;

    // seed vector on the x axis, angle below one quadrant
    assign chain[0].x    = CORDIC_GAIN;
    assign chain[0].y    = '0;
    assign chain[0].z    = signed'({2'b00, phase[PHASE_BITS-3:0]});
    assign chain[0].quad = phase[PHASE_BITS-1:PHASE_BITS-2];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        stec_cell u_cell (
            .aclk (aclk),
            .en   (en),
            .step (STEP_BITS'(i)),
            .cin  (chain[i]),
            .cout (chain[i+1])
        );
    end

    // round to q16, clamp, then fold the quadrant
    always_comb begin
        xr = (chain[CORDIC_STEPS].x + 32'sd8192) >>> 14;
        yr = (chain[CORDIC_STEPS].y + 32'sd8192) >>> 14;
        if (xr > 32'sd65536)       xc = TRIG_ONE;
        else if (xr < -32'sd65536) xc = -TRIG_ONE;
        else                       xc = 18'(xr);
        if (yr > 32'sd65536)       yc = TRIG_ONE;
        else if (yr < -32'sd65536) yc = -TRIG_ONE;
        else                       yc = 18'(yr);
        case (chain[CORDIC_STEPS].quad)
            2'd0:    begin trig_next.c = xc;  trig_next.s = yc;  end
            2'd1:    begin trig_next.c = -yc; trig_next.s = xc;  end
            2'd2:    begin trig_next.c = -xc; trig_next.s = -yc; end
            default: begin trig_next.c = yc;  trig_next.s = -xc; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            trig_reg <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

@@ sv/shift_tensor_euler_coefficients.sv @@
// ----------------------------------------------------------------------------
// shift_tensor_euler_coefficients
// Rotated shift tensor x, y and z coefficients from principal values and
// three Euler angles.
// ----------------------------------------------------------------------------
// One word is accepted every cycle while the output is not stalled, and one
// result word leaves for each, in order. The depth is set by the 28-cell
// cordic row (five rows work side by side for alpha, beta, gamma, twice beta
// and twice gamma), one fold stage, five multiply stages and the output
// register. The whole pipeline holds while a result waits in the output
// register and m_tready is low.
module shift_tensor_euler_coefficients (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tensor_xx, tensor_yy, tensor_zz, angle_alpha, angle_beta, angle_gamma
    input  logic [8*stec_pkg::IN_BYTES-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // coeff_x, coeff_y, coeff_z, zero pad
    output logic [8*stec_pkg::OUT_BYTES-1:0]  m_tdata
);
    import stec_pkg::*;

    localparam int TRIG_LAT = CORDIC_STEPS + 1;
    localparam int LAT      = TRIG_LAT + 5;
    localparam int VB       = VALUE_BITS;
    localparam int AB       = ANGLE_BITS;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic m_tvalid_reg;
    logic [8*OUT_BYTES-1:0] m_tdata_reg, m_tdata_next;

    logic signed [VB-1:0] xx_in, yy_in, zz_in;
    logic [AB-1:0] alpha, beta, gamma;
    logic [PHASE_BITS-1:0] ph_a, ph_b, ph_g, ph_b2, ph_g2;
    trig_t t_a, t_b, t_g, t_b2, t_g2;

    logic signed [VB-1:0] xx_dly [TRIG_LAT];
    logic signed [VB-1:0] yy_dly [TRIG_LAT];
    logic signed [VB-1:0] zz_dly [TRIG_LAT];

    // stage 1
    logic signed [17:0] cg2_reg, sg2_reg, cb2_reg, sb2_reg, sasb_reg, casb_reg;
    logic signed [17:0] cas2b_reg, sas2b_reg, s2g_reg;
    logic signed [VB:0] diff_reg;
    logic signed [VB-1:0] xx1_reg, yy1_reg, zz1_reg;
    // stage 2
    logic signed [17:0] tsa_reg, tca_reg, sb2b_reg, cas2b2_reg, sas2b2_reg;
    logic signed [41:0] pxx_reg, pyy_reg, pzz_reg;
    logic signed [VB:0] diff2_reg;
    logic signed [VB-1:0] zz2_reg;
    // stage 3
    logic signed [34:0] a8_reg;
    logic signed [42:0] dts_reg, dtc_reg;
    logic signed [41:0] pzz3_reg;
    logic signed [17:0] sb2c_reg, cas2b3_reg, sas2b3_reg;
    logic signed [VB-1:0] zz3_reg;
    // stage 4
    logic signed [35:0] d8_reg;
    logic signed [52:0] psb_reg;
    logic signed [42:0] dts4_reg, dtc4_reg;
    logic signed [41:0] pzz4_reg;
    logic signed [17:0] cas2b4_reg, sas2b4_reg;
    // stage 5
    logic signed [53:0] pcx_reg, pcy_reg, zsum_reg;
    logic signed [42:0] dts5_reg, dtc5_reg;

    logic signed [55:0] xsum, ysum;
    logic signed [42:0] sumxy;

    // the pipeline moves whenever the output register can take a word
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // unpack input word
    assign xx_in = signed'(s_tdata[VB-1:0]);
    assign yy_in = signed'(s_tdata[2*VB-1:VB]);
    assign zz_in = signed'(s_tdata[3*VB-1:2*VB]);
    assign alpha = s_tdata[3*VB+AB-1:3*VB];
    assign beta  = s_tdata[3*VB+2*AB-1:3*VB+AB];
    assign gamma = s_tdata[3*VB+3*AB-1:3*VB+2*AB];

    // angles as 32-bit phases, doubled angles wrap modulo one turn
    assign ph_a  = {alpha, (PHASE_BITS-AB)'(0)};
    assign ph_b  = {beta,  (PHASE_BITS-AB)'(0)};
    assign ph_g  = {gamma, (PHASE_BITS-AB)'(0)};
    assign ph_b2 = {beta[AB-2:0],  (PHASE_BITS-AB+1)'(0)};
    assign ph_g2 = {gamma[AB-2:0], (PHASE_BITS-AB+1)'(0)};

    stec_sincos u_sc_a  (.aclk(aclk), .en(en), .phase(ph_a),  .trig(t_a));
    stec_sincos u_sc_b  (.aclk(aclk), .en(en), .phase(ph_b),  .trig(t_b));
    stec_sincos u_sc_g  (.aclk(aclk), .en(en), .phase(ph_g),  .trig(t_g));
    stec_sincos u_sc_b2 (.aclk(aclk), .en(en), .phase(ph_b2), .trig(t_b2));
    stec_sincos u_sc_g2 (.aclk(aclk), .en(en), .phase(ph_g2), .trig(t_g2));

    // final sums and output packing
    always_comb begin
        sumxy = 43'(pxx_reg) + 43'(pyy_reg);
        xsum  = (56'(dts5_reg) <<< 8) + 56'(pcx_reg);
        ysum  = 56'(pcy_reg) - (56'(dtc5_reg) <<< 8);
        m_tdata_next = '0;
        m_tdata_next[OUT_BITS-1:0] =
            sat_out(32'((xsum + 56'sd16777216) >>> 25));
        m_tdata_next[2*OUT_BITS-1:OUT_BITS] =
            sat_out(32'((ysum + 56'sd16777216) >>> 25));
        m_tdata_next[3*OUT_BITS-1:2*OUT_BITS] =
            sat_out(32'((56'(zsum_reg) + 56'sd8388608) >>> 24));
    end

    // valid tracking and output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[LAT-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[LAT-1];
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (en) begin
            // tensor values ride alongside the cordic rows
            xx_dly[0] <= xx_in;
            yy_dly[0] <= yy_in;
            zz_dly[0] <= zz_in;
            for (int i = 1; i < TRIG_LAT; i++) begin
                xx_dly[i] <= xx_dly[i-1];
                yy_dly[i] <= yy_dly[i-1];
                zz_dly[i] <= zz_dly[i-1];
            end
            // squares and angle products
            cg2_reg   <= mul_q16(t_g.c, t_g.c);
            sg2_reg   <= mul_q16(t_g.s, t_g.s);
            cb2_reg   <= mul_q16(t_b.c, t_b.c);
            sb2_reg   <= mul_q16(t_b.s, t_b.s);
            sasb_reg  <= mul_q16(t_a.s, t_b.s);
            casb_reg  <= mul_q16(t_a.c, t_b.s);
            cas2b_reg <= mul_q16(t_a.c, t_b2.s);
            sas2b_reg <= mul_q16(t_a.s, t_b2.s);
            s2g_reg   <= t_g2.s;
            diff_reg  <= (VB+1)'(xx_dly[TRIG_LAT-1]) - (VB+1)'(yy_dly[TRIG_LAT-1]);
            xx1_reg   <= xx_dly[TRIG_LAT-1];
            yy1_reg   <= yy_dly[TRIG_LAT-1];
            zz1_reg   <= zz_dly[TRIG_LAT-1];
            // gamma terms and tensor products
            tsa_reg    <= mul_q16(sasb_reg, s2g_reg);
            tca_reg    <= mul_q16(casb_reg, s2g_reg);
            pxx_reg    <= 42'(xx1_reg) * 42'(cg2_reg);
            pyy_reg    <= 42'(yy1_reg) * 42'(sg2_reg);
            pzz_reg    <= 42'(zz1_reg) * 42'(cb2_reg);
            sb2b_reg   <= sb2_reg;
            cas2b2_reg <= cas2b_reg;
            sas2b2_reg <= sas2b_reg;
            diff2_reg  <= diff_reg;
            zz2_reg    <= zz1_reg;
            // q8 in-plane part and difference terms
            a8_reg     <= 35'((sumxy + 43'sd128) >>> 8);
            dts_reg    <= 43'(diff2_reg) * 43'(tsa_reg);
            dtc_reg    <= 43'(diff2_reg) * 43'(tca_reg);
            pzz3_reg   <= pzz_reg;
            sb2c_reg   <= sb2b_reg;
            cas2b3_reg <= cas2b2_reg;
            sas2b3_reg <= sas2b2_reg;
            zz3_reg    <= zz2_reg;
            // axial remainder and z product
            d8_reg     <= (36'(zz3_reg) <<< 8) - 36'(a8_reg);
            psb_reg    <= 53'(sb2c_reg) * 53'(a8_reg);
            dts4_reg   <= dts_reg;
            dtc4_reg   <= dtc_reg;
            pzz4_reg   <= pzz3_reg;
            cas2b4_reg <= cas2b3_reg;
            sas2b4_reg <= sas2b3_reg;
            // off-axis products and z sum
            pcx_reg  <= 54'(cas2b4_reg) * 54'(d8_reg);
            pcy_reg  <= 54'(sas2b4_reg) * 54'(d8_reg);
            zsum_reg <= (54'(pzz4_reg) <<< 8) + 54'(psb_reg);
            dts5_reg <= dts4_reg;
            dtc5_reg <= dtc4_reg;
            // output register
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

@@ sv/stec_checker.sv @@
// ----------------------------------------------------------------------------
// stec_checker
// Port-level checks for the shift tensor coefficient block.
// ----------------------------------------------------------------------------
module stec_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [8*stec_pkg::IN_BYTES-1:0]   s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [8*stec_pkg::OUT_BYTES-1:0]  m_tdata
);
    import stec_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // input side is ready exactly when the output can move
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output");

    // nothing valid right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // pad bits above the three coefficients stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[8*OUT_BYTES-1:3*OUT_BITS] == '0)
        else $error("pad bits set in result word");

    // an offered input word carries known data
    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid |-> !$isunknown(s_tdata))
        else $error("unknown bits in offered input word");

endmodule

bind shift_tensor_euler_coefficients stec_checker u_stec_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
